@@ rtl/core/pdc_pkg.sv @@
// Package for the PID position controller with dead band and clamps.
// Holds field widths, configuration index codes and the structs passed
// between pipeline stages. No dependencies.
`default_nettype none
package pdc_pkg;

  localparam int InW    = 16;
  localparam int GainW  = 24;
  localparam int BandW  = 16;
  localparam int LimW   = 20;
  localparam int ErrW   = 17;
  localparam int AccW   = 21;
  localparam int DErrW  = 18;
  localparam int DriveW = 21;
  localparam int FracW  = 16;
  localparam int PW     = GainW + 1 + ErrW;
  localparam int IW     = GainW + 1 + AccW;
  localparam int DW     = GainW + 1 + DErrW;
  localparam int ICW    = LimW + FracW + 1;
  localparam int PDW    = DW + 1;
  localparam int SumW   = IW;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = GainW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_DEAD_BAND   = 3'd3,
    CFG_INTEG_LIMIT = 3'd4,
    CFG_ITERM_LIMIT = 3'd5,
    CFG_OUT_LIMIT   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_i;
    logic [GainW-1:0] gain_d;
    logic [BandW-1:0] dead_band;
    logic [LimW-1:0]  integ_limit;
    logic [LimW-1:0]  iterm_limit;
    logic [LimW-1:0]  out_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [AccW-1:0]  acc;
    logic signed [DErrW-1:0] derr;
  } err_data_t;

  typedef struct packed {
    logic signed [PW-1:0] p;
    logic signed [IW-1:0] i;
    logic signed [DW-1:0] d;
  } prod_t;

  typedef struct packed {
    logic signed [ICW-1:0] iterm;
    logic signed [PDW-1:0] pd;
  } part_t;

endpackage
`default_nettype wire

@@ rtl/core/pid_position_deadband_clamp.sv @@
// Top level of the positional PID controller with dead band and clamps.
// Holds the configuration registers and chains the four pipeline stages.
// Depends on pdc_pkg and the pdc_*_stage modules.
//
// Usage: each input transaction on in_valid/in_ready carries one setpoint
// and one measured value; each one yields exactly one output transaction
// on out_valid/out_ready carrying the clamped drive value.
// The pipeline has four register stages: error and accumulator, products,
// partial sums and the result register, which each transaction passes in
// that order. One transaction can be accepted every cycle while the
// pipeline is not stalled by out_ready.
// Every stage holds its data while the one after it is full and stalled,
// so a stall on out_ready fills the pipeline and then drops in_ready; up
// to four transactions are in flight. The controller state (accumulator
// and previous error) advances only when an input transaction is accepted.
// Configuration writes on cfg_we take effect at the next edge and must be
// made while the pipeline is empty. Reset clears all configuration
// registers, the controller state and every stage valid bit.
`default_nettype none
module pid_position_deadband_clamp
  import pdc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CfgIdxW-1:0]         cfg_index,
  input  wire logic [CfgDataW-1:0]        cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [InW-1:0]      in_setpoint,
  input  wire logic signed [InW-1:0]      in_measured,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [DriveW-1:0]        out_drive
);

  cfg_t      cfg_r;
  logic      a_valid;
  logic      a_ready;
  err_data_t a_data;
  logic      b_valid;
  logic      b_ready;
  prod_t     b_data;
  logic      c_valid;
  logic      c_ready;
  part_t     c_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P:      cfg_r.gain_p      <= cfg_wdata[GainW-1:0];
        CFG_GAIN_I:      cfg_r.gain_i      <= cfg_wdata[GainW-1:0];
        CFG_GAIN_D:      cfg_r.gain_d      <= cfg_wdata[GainW-1:0];
        CFG_DEAD_BAND:   cfg_r.dead_band   <= cfg_wdata[BandW-1:0];
        CFG_INTEG_LIMIT: cfg_r.integ_limit <= cfg_wdata[LimW-1:0];
        CFG_ITERM_LIMIT: cfg_r.iterm_limit <= cfg_wdata[LimW-1:0];
        CFG_OUT_LIMIT:   cfg_r.out_limit   <= cfg_wdata[LimW-1:0];
        default: begin
        end
      endcase
    end
  end

  pdc_err_stage u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .setpoint (in_setpoint),
    .measured (in_measured),
    .dn_valid (a_valid),
    .dn_ready (a_ready),
    .dn_data  (a_data)
  );

  pdc_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (a_valid),
    .up_ready (a_ready),
    .up_data  (a_data),
    .dn_valid (b_valid),
    .dn_ready (b_ready),
    .dn_data  (b_data)
  );

  pdc_add_stage u_add (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (b_valid),
    .up_ready (b_ready),
    .up_data  (b_data),
    .dn_valid (c_valid),
    .dn_ready (c_ready),
    .dn_data  (c_data)
  );

  pdc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (c_valid),
    .up_ready (c_ready),
    .up_data  (c_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_drive (out_drive)
  );

  // An empty result register means every stage can take a transaction.
  a_empty_out_means_ready: assert property (
    @(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready
  ) else $error("input stalled while the result register is empty");

  a_accept_fills_stage: assert property (
    @(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> a_valid
  ) else $error("accepted transaction did not reach the error stage");

  a_stalled_stage_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    (a_valid && !a_ready) |=> (a_valid && $stable(a_data))
  ) else $error("error stage lost or changed data while stalled");

  a_stalled_out_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    (c_valid && !c_ready) |=> (c_valid && out_valid && !out_ready) || c_ready
  ) else $error("partial sum stage stalled without a stalled result");

endmodule
`default_nettype wire

@@ rtl/core/pdc_err_stage.sv @@
// Error stage: error, dead band, clamped accumulator and error difference.
// Holds the controller state. Depends on pdc_pkg.
`default_nettype none
module pdc_err_stage
  import pdc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire logic                   up_valid,
  output logic                        up_ready,
  input  wire logic signed [InW-1:0]  setpoint,
  input  wire logic signed [InW-1:0]  measured,
  output logic                        dn_valid,
  input  wire logic                   dn_ready,
  output err_data_t                   dn_data
);

  logic                    valid_r;
  err_data_t               data_r;
  logic signed [AccW-1:0]  acc_r;
  logic signed [AccW-1:0]  acc_nxt;
  logic signed [ErrW-1:0]  prev_r;
  logic signed [ErrW-1:0]  err_raw;
  logic signed [ErrW-1:0]  err_db;
  logic signed [ErrW:0]    err_wide;
  logic signed [ErrW:0]    band;
  logic signed [AccW:0]    acc_sum;
  logic signed [AccW:0]    acc_lim;
  logic signed [DErrW-1:0] derr;
  logic                    take;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;

  always_comb begin
    err_raw  = ErrW'(setpoint) - ErrW'(measured);
    err_wide = (ErrW+1)'(err_raw);
    band     = $signed({2'b00, cfg.dead_band});
    if ((err_wide > -band) && (err_wide < band)) begin
      err_db = '0;
    end else begin
      err_db = err_raw;
    end
    acc_sum = (AccW+1)'(acc_r) + (AccW+1)'(err_db);
    acc_lim = $signed({2'b00, cfg.integ_limit});
    if (acc_sum > acc_lim) begin
      acc_nxt = acc_lim[AccW-1:0];
    end else if (acc_sum < -acc_lim) begin
      acc_nxt = AccW'(-acc_lim);
    end else begin
      acc_nxt = acc_sum[AccW-1:0];
    end
    derr = DErrW'(err_db) - DErrW'(prev_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      acc_r   <= '0;
      prev_r  <= '0;
    end else begin
      if (up_ready) begin
        valid_r <= up_valid;
      end
      if (take) begin
        acc_r  <= acc_nxt;
        prev_r <= err_db;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r.err  <= err_db;
      data_r.acc  <= acc_nxt;
      data_r.derr <= derr;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

@@ rtl/core/pdc_mul_stage.sv @@
// Multiply stage: forms the P, I and D products with Q8.16 gains.
// Depends on pdc_pkg.
`default_nettype none
module pdc_mul_stage
  import pdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire err_data_t up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output prod_t          dn_data
);

  logic  valid_r;
  prod_t data_r;
  prod_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    data_nxt.p = PW'($signed({1'b0, cfg.gain_p})) * PW'($signed(up_data.err));
    data_nxt.i = IW'($signed({1'b0, cfg.gain_i})) * IW'($signed(up_data.acc));
    data_nxt.d = DW'($signed({1'b0, cfg.gain_d})) * DW'($signed(up_data.derr));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

@@ rtl/core/pdc_add_stage.sv @@
// Partial sum stage: clamps the I term and adds the P and D terms.
// Depends on pdc_pkg.
`default_nettype none
module pdc_add_stage
  import pdc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire prod_t up_data,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output part_t      dn_data
);

  logic                 valid_r;
  part_t                data_r;
  part_t                data_nxt;
  logic signed [IW-1:0] ilim;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    ilim = IW'($signed({1'b0, cfg.iterm_limit, {FracW{1'b0}}}));
    if (up_data.i > ilim) begin
      data_nxt.iterm = ilim[ICW-1:0];
    end else if (up_data.i < -ilim) begin
      data_nxt.iterm = ICW'(-ilim);
    end else begin
      data_nxt.iterm = up_data.i[ICW-1:0];
    end
    data_nxt.pd = PDW'(up_data.p) + PDW'(up_data.d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

@@ rtl/core/pdc_out_stage.sv @@
// Output stage: final sum, truncation toward zero and output clamp,
// feeding the result register. Depends on pdc_pkg.
`default_nettype none
module pdc_out_stage
  import pdc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     up_valid,
  output logic                          up_ready,
  input  wire part_t                    up_data,
  output logic                          dn_valid,
  input  wire logic                     dn_ready,
  output logic signed [DriveW-1:0]      dn_drive
);

  localparam int QW = SumW - FracW;

  logic                     valid_r;
  logic signed [DriveW-1:0] drive_r;
  logic signed [DriveW-1:0] drive_nxt;
  logic signed [SumW-1:0]   total;
  logic signed [QW-1:0]     quot;
  logic signed [QW-1:0]     lim;
  logic                     round_up;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    total    = SumW'(up_data.iterm) + SumW'(up_data.pd);
    round_up = total[SumW-1] && (|total[FracW-1:0]);
    quot     = $signed(total[SumW-1:FracW]) + $signed({{(QW-1){1'b0}}, round_up});
    lim      = $signed({{(QW-LimW){1'b0}}, cfg.out_limit});
    if (quot > lim) begin
      drive_nxt = lim[DriveW-1:0];
    end else if (quot < -lim) begin
      drive_nxt = DriveW'(-lim);
    end else begin
      drive_nxt = quot[DriveW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      drive_r <= drive_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_drive = drive_r;

endmodule
`default_nettype wire

@@ sim/tb_pid_position_deadband_clamp.sv @@
// Self-checking testbench for pid_position_deadband_clamp. Random and directed
// setpoint/measured transactions are checked against a cycle-free controller model.
// Depends on pdc_pkg and the RTL of the controller.
module tb_pid_position_deadband_clamp;
  import pdc_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;
  localparam int IdlePct = 24;
  localparam int RxHoldCycles = 300;

  typedef struct {
    logic signed [InW-1:0] setpoint;
    logic signed [InW-1:0] measured;
  } tick_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [InW-1:0] in_setpoint = '0;
  logic signed [InW-1:0] in_measured = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DriveW-1:0] out_drive;

  tick_t tick_q[$];
  logic signed [DriveW-1:0] drive_due_q[$];
  cfg_t model_cfg = '0;
  longint model_accum = 0;
  longint model_prev_err = 0;
  int fail_count = 0;
  bit no_idle = 1'b0;
  bit rx_hold_arm = 1'b0;
  int rx_hold_left = 0;

  pid_position_deadband_clamp u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_setpoint(in_setpoint),
    .in_measured(in_measured),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_drive  (out_drive)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [DriveW-1:0] compute_drive(tick_t t);
    longint err, band, pterm, iterm, dterm, sum;
    err = longint'(t.setpoint) - longint'(t.measured);
    band = longint'(model_cfg.dead_band);
    if (err > -band && err < band) err = 0;
    model_accum = clamp_sym(model_accum + err, longint'(model_cfg.integ_limit));
    pterm = longint'(model_cfg.gain_p) * err;
    iterm = longint'(model_cfg.gain_i) * model_accum;
    dterm = longint'(model_cfg.gain_d) * (err - model_prev_err);
    iterm = clamp_sym(iterm, longint'(model_cfg.iterm_limit) <<< FracW);
    sum = clamp_sym(pterm + iterm + dterm, longint'(model_cfg.out_limit) <<< FracW);
    model_prev_err = err;
    sum = sum / (longint'(1) <<< FracW);
    return sum[DriveW-1:0];
  endfunction

  always @(posedge clk) begin
    tick_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        t.setpoint = in_setpoint;
        t.measured = in_measured;
        drive_due_q.push_back(compute_drive(t));
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
          t = tick_q.pop_front();
          in_valid <= 1'b1;
          in_setpoint <= t.setpoint;
          in_measured <= t.measured;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic signed [DriveW-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_due_q.size() == 0) begin
          $error("drive: unexpected transaction, actual %0d", out_drive);
          fail_count++;
        end else begin
          want = drive_due_q.pop_front();
          if (out_drive !== want) begin
            $error("drive: expected %0d, actual %0d", want, out_drive);
            fail_count++;
          end
        end
      end
      if (rx_hold_arm) begin
        rx_hold_arm = 1'b0;
        rx_hold_left = RxHoldCycles;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || $urandom_range(99) >= IdlePct;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_GAIN_P:      model_cfg.gain_p = data;
      CFG_GAIN_I:      model_cfg.gain_i = data;
      CFG_GAIN_D:      model_cfg.gain_d = data;
      CFG_DEAD_BAND:   model_cfg.dead_band = data[BandW-1:0];
      CFG_INTEG_LIMIT: model_cfg.integ_limit = data[LimW-1:0];
      CFG_ITERM_LIMIT: model_cfg.iterm_limit = data[LimW-1:0];
      CFG_OUT_LIMIT:   model_cfg.out_limit = data[LimW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_tick(int sp, int meas);
    tick_t t;
    t.setpoint = sp[InW-1:0];
    t.measured = meas[InW-1:0];
    tick_q.push_back(t);
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || drive_due_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [CfgDataW-1:0] pick_value(int unsigned typical);
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(typical));
    endcase
  endfunction

  task automatic push_random_tick();
    int sp, meas, span;
    sp = $signed(16'($urandom));
    span = int'(model_cfg.dead_band) + 8;
    if (span > 2000) span = 2000;
    case ($urandom_range(3))
      0: meas = $signed(16'($urandom));
      1, 2: begin
        meas = sp - (int'($urandom_range(2 * span)) - span);
        if (meas > 32767) meas = 32767;
        if (meas < -32768) meas = -32768;
      end
      default: meas = sp;
    endcase
    push_tick(sp, meas);
  endtask

  initial begin : stimulus
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still at their reset values: every clamp limit is zero.
    push_tick(1000, -1000);
    push_tick(-32768, 32767);
    wait_drained();

    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_GAIN_P, 24'h010000);
    write_reg(CFG_GAIN_I, 24'h001000);
    write_reg(CFG_GAIN_D, 24'h008000);
    write_reg(CFG_DEAD_BAND, 24'd100);
    write_reg(CFG_INTEG_LIMIT, 24'd1000);
    write_reg(CFG_ITERM_LIMIT, 24'd50);
    write_reg(CFG_OUT_LIMIT, 24'd60000);
    push_tick(32767, -32768);
    push_tick(-32768, 32767);
    push_tick(0, 0);
    push_tick(100, 0);
    push_tick(0, 100);
    push_tick(99, 0);
    push_tick(0, 99);
    push_tick(-32768, -32768);
    push_tick(32767, 32767);
    push_tick(5, 5);
    wait_drained();

    // Dead band disabled, then every limit forced to zero.
    write_reg(CFG_DEAD_BAND, '0);
    push_tick(1, 0);
    push_tick(0, 1);
    push_tick(0, 0);
    wait_drained();
    write_reg(CFG_INTEG_LIMIT, '0);
    write_reg(CFG_ITERM_LIMIT, '0);
    write_reg(CFG_OUT_LIMIT, '0);
    push_tick(1000, 0);
    push_tick(-1000, 0);
    wait_drained();

    // All registers at their maximum; the band edge sits at the largest error.
    for (int r = CFG_GAIN_P; r <= CFG_OUT_LIMIT; r++) write_reg(CfgIdxW'(r), '1);
    push_tick(32767, -32768);
    push_tick(-32768, 32767);
    push_tick(32767, -32767);
    push_tick(0, 0);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_GAIN_P, pick_value(24'h040000));
      write_reg(CFG_GAIN_I, pick_value(24'h010000));
      write_reg(CFG_GAIN_D, pick_value(24'h040000));
      write_reg(CFG_DEAD_BAND, pick_value(400));
      write_reg(CFG_INTEG_LIMIT, pick_value(5000));
      write_reg(CFG_ITERM_LIMIT, pick_value(2000));
      write_reg(CFG_OUT_LIMIT, pick_value(50000));
      no_idle = (ph == 3);
      n = 125;
      if (ph == 8) begin
        for (int k = 0; k < 60; k++) push_random_tick();
        wait_drained();
        n = 65;
      end
      for (int k = 0; k < n; k++) push_random_tick();
      if (ph == 6) rx_hold_arm = 1'b1;
      wait_drained();
    end
    no_idle = 1'b0;

    n = 0;
    while ((in_valid || drive_due_q.size() != 0) && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (drive_due_q.size() != 0) begin
      $error("drive: %0d expected transactions never arrived", drive_due_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
